@@ hw/rtl/lzwdt_pkg.sv @@
// Shared types and codes for the LZW dictionary table.
// Used by the controller, the datapath, the top level and the port checker.
package lzwdt_pkg;

	localparam int CMD_W    = 2;
	localparam int PREFIX_W = 12;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 12;
	localparam int CWIDTH_W = 4;

	// Command codes carried by an input item
	localparam logic [CMD_W-1:0] CMD_FIND  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FLUSHED   = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
		logic scan_start;
		logic scan_run;
		logic scan_hit;
		logic scan_miss;
		logic load_out;
	} lzwdt_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic need_scan;
		logic hit;
		logic drained;
		logic out_free;
	} lzwdt_stat_t;

endpackage

@@ hw/rtl/lzwdt_ctrl.sv @@
// Sequencer of the LZW dictionary table: accept, execute, scan, deliver.
// Depends on lzwdt_pkg for the command and status structs.
module lzwdt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lzwdt_pkg::lzwdt_stat_t stat,
	output lzwdt_pkg::lzwdt_cmd_t  cmd
);
	import lzwdt_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_PUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.need_scan) begin
					cmd.scan_start = 1'b1;
					state_nxt      = S_SCAN;
				end else begin
					cmd.exec  = 1'b1;
					state_nxt = S_PUT;
				end
			end
			S_SCAN: begin
				// a compare hit wins over the drained flag of the same cycle
				if (stat.hit) begin
					cmd.scan_hit = 1'b1;
					state_nxt    = S_PUT;
				end else if (stat.drained) begin
					cmd.scan_miss = 1'b1;
					state_nxt     = S_PUT;
				end else begin
					cmd.scan_run = 1'b1;
				end
			end
			S_PUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ hw/rtl/lzwdt_dpath.sv @@
// Datapath of the LZW dictionary table: entry memory, counters, scan
// pipeline and output register. Depends on lzwdt_pkg.
module lzwdt_dpath #(
	parameter int MAX_BITS     = 12,
	parameter int INIT_WIDTH   = 9,
	parameter int TABLE_DEPTH  = 4096,
	parameter int ROOT_ENTRIES = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lzwdt_pkg::lzwdt_cmd_t             cmd,
	output lzwdt_pkg::lzwdt_stat_t            stat,
	input  logic [lzwdt_pkg::CMD_W-1:0]       in_cmd,
	input  logic                              in_prefix_nil,
	input  logic [lzwdt_pkg::PREFIX_W-1:0]    in_prefix_code,
	input  logic [lzwdt_pkg::BYTE_W-1:0]      in_symbol_byte,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [lzwdt_pkg::STATUS_W-1:0]    out_status,
	output logic [lzwdt_pkg::INDEX_W-1:0]     out_entry_index,
	output logic [lzwdt_pkg::CWIDTH_W-1:0]    out_code_width
);
	import lzwdt_pkg::*;

	localparam int AW      = $clog2(TABLE_DEPTH);
	localparam int CW      = $clog2(TABLE_DEPTH + 1);
	localparam int WMAX    = (MAX_BITS > INIT_WIDTH) ? MAX_BITS : INIT_WIDTH;
	localparam int WW      = $clog2(WMAX + 2);
	localparam int ENTRY_W = 1 + PREFIX_W + BYTE_W;

	// captured item
	logic [CMD_W-1:0]    cmd_q;
	logic                nil_q;
	logic [PREFIX_W-1:0] pcode_q;
	logic [BYTE_W-1:0]   sym_q;

	logic [CW-1:0] used_q;
	logic [WW-1:0] width_q;

	logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

	logic [CW-1:0]      scan_q;
	logic               rd_pend_s1;
	logic [AW-1:0]      rd_addr_s1;
	logic [ENTRY_W-1:0] rd_word_s1;

	logic [STATUS_W-1:0] res_status_q;
	logic [INDEX_W-1:0]  res_index_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [INDEX_W-1:0]  out_index_q;
	logic [CWIDTH_W-1:0] out_width_q;

	logic                issue;
	logic                rd_en;
	logic                match;
	logic                full;
	logic                grow;
	logic [WW-1:0]       width_inc;
	logic                wr_en;
	logic [ENTRY_W-1:0]  wr_word;
	logic [STATUS_W-1:0] exec_status;
	logic [INDEX_W-1:0]  exec_index;

	assign issue = (scan_q < used_q);
	assign rd_en = cmd.scan_run && issue;
	assign match = rd_pend_s1 && !rd_word_s1[ENTRY_W-1]
		&& (rd_word_s1[ENTRY_W-2:BYTE_W] == pcode_q)
		&& (rd_word_s1[BYTE_W-1:0] == sym_q);

	assign stat.need_scan = (cmd_q == CMD_FIND) && !nil_q;
	assign stat.hit       = match;
	assign stat.drained   = !issue && !rd_pend_s1;
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign full      = (used_q >= CW'(TABLE_DEPTH));
	assign grow      = (32'(used_q) == (32'd1 << width_q));
	assign width_inc = width_q + 1'b1;
	assign wr_en     = cmd.exec && (cmd_q == CMD_ADD) && !full;
	assign wr_word   = {nil_q, (nil_q ? {PREFIX_W{1'b0}} : pcode_q), sym_q};

	always_comb begin
		exec_status = ST_OK;
		exec_index  = '0;
		case (cmd_q)
			CMD_FIND:  exec_index  = INDEX_W'(sym_q);
			CMD_ADD:   exec_status = full ? ST_FULL : ST_OK;
			CMD_FLUSH: exec_status = (grow && (width_inc > WW'(MAX_BITS))) ? ST_FLUSHED : ST_OK;
			default:   exec_status = ST_OK;
		endcase
	end

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[used_q[AW-1:0]] <= wr_word;
		end
		if (rd_en) begin
			rd_word_s1 <= mem[scan_q[AW-1:0]];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q   <= in_cmd;
			nil_q   <= in_prefix_nil;
			pcode_q <= in_prefix_code;
			sym_q   <= in_symbol_byte;
		end
		if (rd_en) begin
			rd_addr_s1 <= scan_q[AW-1:0];
		end
		if (cmd.exec) begin
			res_status_q <= exec_status;
			res_index_q  <= exec_index;
		end else if (cmd.scan_hit) begin
			res_status_q <= ST_OK;
			res_index_q  <= INDEX_W'(rd_addr_s1);
		end else if (cmd.scan_miss) begin
			res_status_q <= ST_NOT_FOUND;
			res_index_q  <= '0;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_width_q  <= CWIDTH_W'(width_q);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= CW'(ROOT_ENTRIES);
			width_q     <= WW'(INIT_WIDTH);
			scan_q      <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				used_q <= used_q + 1'b1;
			end
			if (cmd.exec && (cmd_q == CMD_FLUSH) && grow) begin
				if (width_inc > WW'(MAX_BITS)) begin
					width_q <= WW'(INIT_WIDTH);
					used_q  <= CW'(ROOT_ENTRIES);
				end else begin
					width_q <= width_inc;
				end
			end
			// the scan starts past the root entries, so they never match a scan
			if (cmd.scan_start) begin
				scan_q     <= CW'(ROOT_ENTRIES);
				rd_pend_s1 <= 1'b0;
			end else begin
				if (rd_en) begin
					scan_q <= scan_q + 1'b1;
				end
				rd_pend_s1 <= rd_en;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_status      = out_status_q;
	assign out_entry_index = out_index_q;
	assign out_code_width  = out_width_q;

endmodule

@@ hw/rtl/lzw_dictionary_table.sv @@
// LZW dictionary table. One item in, one result out, one item at a time.
// Add, flush/width check, nil-prefix find and unknown commands go from accept
// through the execute and deliver states into the output register; delivery
// waits while a held result is stalled. A find with a non-nil prefix scans the
// appended entries (index 256 up to the entry count) one per cycle through
// the single read port of the entry memory. The memory needs no clearing pass
// after reset: only written entries are ever read. A finished result waits in
// the output register while the next item is accepted.
// Depends on lzwdt_pkg, lzwdt_ctrl and lzwdt_dpath.
module lzw_dictionary_table #(
	parameter int MAX_BITS     = 12,
	parameter int INIT_WIDTH   = 9,
	parameter int TABLE_DEPTH  = 4096,
	parameter int ROOT_ENTRIES = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lzwdt_pkg::CMD_W-1:0]    cmd,
	input  logic                           prefix_nil,
	input  logic [lzwdt_pkg::PREFIX_W-1:0] prefix_code,
	input  logic [lzwdt_pkg::BYTE_W-1:0]   symbol_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lzwdt_pkg::STATUS_W-1:0] status,
	output logic [lzwdt_pkg::INDEX_W-1:0]  entry_index,
	output logic [lzwdt_pkg::CWIDTH_W-1:0] code_width
);
	import lzwdt_pkg::*;

	lzwdt_cmd_t  ctl_cmd;
	lzwdt_stat_t ctl_stat;

	lzwdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (ctl_stat),
		.cmd      (ctl_cmd)
	);

	lzwdt_dpath #(
		.MAX_BITS     (MAX_BITS),
		.INIT_WIDTH   (INIT_WIDTH),
		.TABLE_DEPTH  (TABLE_DEPTH),
		.ROOT_ENTRIES (ROOT_ENTRIES)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (ctl_cmd),
		.stat            (ctl_stat),
		.in_cmd          (cmd),
		.in_prefix_nil   (prefix_nil),
		.in_prefix_code  (prefix_code),
		.in_symbol_byte  (symbol_byte),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.out_status      (status),
		.out_entry_index (entry_index),
		.out_code_width  (code_width)
	);

endmodule

@@ hw/rtl/lzwdt_checker.sv @@
// Port-level checks for the LZW dictionary table, bound to the top level.
// Depends on lzwdt_pkg for the status codes.
module lzwdt_checker #(
	parameter int INIT_WIDTH = 9
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [lzwdt_pkg::STATUS_W-1:0] status,
	input logic [lzwdt_pkg::INDEX_W-1:0]  entry_index,
	input logic [lzwdt_pkg::CWIDTH_W-1:0] code_width
);
	import lzwdt_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(entry_index) && $stable(code_width))
		else $error("stalled result changed");

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted twice in a row");

	// a flush back to the roots restarts the code width
	a_flush_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FLUSHED) |-> code_width == CWIDTH_W'(INIT_WIDTH))
		else $error("flushed result with wrong code width");

	// results without an index carry zero
	a_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NOT_FOUND || status == ST_FULL
			|| status == ST_FLUSHED) |-> entry_index == '0)
		else $error("nonzero index on a result without an index");

endmodule

bind lzw_dictionary_table lzwdt_checker #(
	.INIT_WIDTH (INIT_WIDTH)
) u_lzwdt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.entry_index (entry_index),
	.code_width  (code_width)
);
